@@ rtl/tmp_pkg.sv @@
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared codes for the triangle midpoint projector: register indexes, edge
// codes and the edge endpoint table.
// ----------------------------------------------------------------------------
`default_nettype none
package tmp_pkg;

	localparam int N_EDGES      = 3;
	localparam int N_VTX        = 3;
	localparam int N_COMP       = 4;
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_OFFSET_X = 3'd0,
		CFG_SCALE_X  = 3'd1,
		CFG_OFFSET_Y = 3'd2,
		CFG_SCALE_Y  = 3'd3,
		CFG_OFFSET_Z = 3'd4,
		CFG_SCALE_Z  = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EDGE_AB = 2'd0,
		EDGE_BC = 2'd1,
		EDGE_AC = 2'd2
	} edge_t;

	// component slots
	localparam int COMP_X = 0;
	localparam int COMP_Y = 1;
	localparam int COMP_Z = 2;
	localparam int COMP_W = 3;

	// endpoints of each edge
	localparam int END_A [N_EDGES] = '{0, 1, 0};
	localparam int END_B [N_EDGES] = '{1, 2, 2};

endpackage
`default_nettype wire

@@ rtl/tmp_if.sv @@
// ----------------------------------------------------------------------------
// tmp_if
// Valid/ready channels of the triangle midpoint projector: triangle input,
// result output and register write.
// ----------------------------------------------------------------------------
`default_nettype none
interface tmp_item_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] a_x, a_y, a_z, a_w;
	logic signed [W-1:0] b_x, b_y, b_z, b_w;
	logic signed [W-1:0] c_x, c_y, c_z, c_w;
	modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
		c_x, c_y, c_z, c_w, input ready);
	modport sink (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
		c_x, c_y, c_z, c_w, output ready);
endinterface

interface tmp_res_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic [1:0]          edge_res;
	logic signed [W-1:0] mid_x, mid_y, mid_z, mid_w;
	logic signed [W-1:0] screen_x, screen_y, screen_z;
	logic                w_fault;
	logic                last;
	modport source (output valid, edge_res, mid_x, mid_y, mid_z, mid_w,
		screen_x, screen_y, screen_z, w_fault, last, input ready);
	modport sink (input valid, edge_res, mid_x, mid_y, mid_z, mid_w,
		screen_x, screen_y, screen_z, w_fault, last, output ready);
endinterface

interface tmp_cfg_if #(parameter int W = 32);
	logic                               valid;
	logic                               ready;
	logic [tmp_pkg::CFG_IDX_BITS-1:0]   index;
	logic [W-1:0]                       data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/tmp_qmul.sv @@
// ----------------------------------------------------------------------------
// tmp_qmul
// Registered fixed-point multiply: magnitude product shifted right by F,
// truncated toward zero, saturated to the signed W range.
// ----------------------------------------------------------------------------
`default_nettype none
module tmp_qmul #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic signed [W-1:0] p,
	output logic                ovf
);
	logic [W-1:0]   ma, mb;
	logic           neg;
	logic [2*W-1:0] prod, sh, lim, m;
	logic           sat;

	always_comb begin
		ma   = a[W-1] ? (~a + 1'b1) : a;
		mb   = b[W-1] ? (~b + 1'b1) : b;
		neg  = a[W-1] ^ b[W-1];
		prod = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
		sh   = prod >> F;
		lim  = ((2*W)'(1) << (W - 1)) - (neg ? (2*W)'(0) : (2*W)'(1));
		sat  = sh > lim;
		m    = sat ? lim : sh;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p   <= neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
			ovf <= sat;
		end
	end
endmodule
`default_nettype wire

@@ rtl/tmp_recip.sv @@
// ----------------------------------------------------------------------------
// tmp_recip
// Pipelined restoring divider for 2^(2F) / |P|, one quotient bit per stage,
// with sign, saturation and zero handling on the last stage.
// ----------------------------------------------------------------------------
`default_nettype none
module tmp_recip #(
	parameter int W       = 32,
	parameter int F       = 16,
	parameter int PL_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [W-1:0] p,
	input  logic [PL_BITS-1:0]  pl_in,
	output logic                out_valid,
	output logic signed [W-1:0] rcp,
	output logic                sat,
	output logic [PL_BITS-1:0]  pl_out
);
	localparam int QB = 2 * F + 1;
	localparam int CW = ((QB > W) ? QB : W) + 1;

	logic [W:0]         r_q  [QB];
	logic [QB-1:0]      q_q  [QB];
	logic [W-1:0]       d_q  [QB];
	logic               neg_q[QB];
	logic               zero_q[QB];
	logic [PL_BITS-1:0] pl_q [QB];
	logic               v_q  [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [W:0]         r_in, r_sh;
		logic [QB-1:0]      q_in;
		logic [W-1:0]       d_in;
		logic               neg_in, zero_in, v_in, ge;
		logic [PL_BITS-1:0] pl_k;
		if (k == 0) begin : g_first
			assign r_in    = '0;
			assign q_in    = '0;
			assign d_in    = p[W-1] ? (~p + 1'b1) : p;
			assign neg_in  = p[W-1];
			assign zero_in = (p == '0);
			assign pl_k    = pl_in;
			assign v_in    = in_valid;
		end else begin : g_next
			assign r_in    = r_q[k-1];
			assign q_in    = q_q[k-1];
			assign d_in    = d_q[k-1];
			assign neg_in  = neg_q[k-1];
			assign zero_in = zero_q[k-1];
			assign pl_k    = pl_q[k-1];
			assign v_in    = v_q[k-1];
		end
		assign r_sh = {r_in[W-1:0], (k == 0) ? 1'b1 : 1'b0};
		assign ge   = r_sh >= {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				r_q[k]    <= ge ? (r_sh - {1'b0, d_in}) : r_sh;
				q_q[k]    <= {q_in[QB-2:0], ge};
				d_q[k]    <= d_in;
				neg_q[k]  <= neg_in;
				zero_q[k] <= zero_in;
				pl_q[k]   <= pl_k;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_in;
			end
		end
	end

	logic [CW-1:0] qx, lim, m;
	logic          over;

	always_comb begin
		qx   = CW'(q_q[QB-1]);
		lim  = (CW'(1) << (W - 1)) - (neg_q[QB-1] ? CW'(0) : CW'(1));
		over = qx > lim;
		m    = over ? lim : qx;
		if (zero_q[QB-1]) begin
			rcp = {1'b0, {(W-1){1'b1}}};
		end else begin
			rcp = neg_q[QB-1] ? (~m[W-1:0] + 1'b1) : m[W-1:0];
		end
		sat       = zero_q[QB-1] | over;
		pl_out    = pl_q[QB-1];
		out_valid = v_q[QB-1];
	end
endmodule
`default_nettype wire

@@ rtl/tmp_lane.sv @@
// ----------------------------------------------------------------------------
// tmp_lane
// Projection lane for one edge midpoint: 1/w from the shared reciprocal,
// scale times coordinate times 1/w, plus offset. Three stages.
// ----------------------------------------------------------------------------
`default_nettype none
module tmp_lane #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] pair,
	input  logic signed [W-1:0] rcp,
	input  logic signed [W-1:0] mx, my, mz,
	input  logic signed [W-1:0] sx, sy, sz,
	input  logic signed [W-1:0] ox, oy, oz,
	output logic signed [W-1:0] scr_x, scr_y, scr_z,
	output logic                inv_ovf
);
	logic signed [W-1:0] inv_s1, tx_s1, ty_s1, tz_s1;
	logic signed [W-1:0] ux_s2, uy_s2, uz_s2;
	logic                ovf_s1, ovf_s2, unused_x, unused_y, unused_z;
	logic                unused_a, unused_b, unused_c;

	tmp_qmul #(.W(W), .F(F)) u_inv (.clk, .en, .a(pair), .b(rcp), .p(inv_s1), .ovf(ovf_s1));
	tmp_qmul #(.W(W), .F(F)) u_tx (.clk, .en, .a(sx), .b(mx), .p(tx_s1), .ovf(unused_x));
	tmp_qmul #(.W(W), .F(F)) u_ty (.clk, .en, .a(sy), .b(my), .p(ty_s1), .ovf(unused_y));
	tmp_qmul #(.W(W), .F(F)) u_tz (.clk, .en, .a(sz), .b(mz), .p(tz_s1), .ovf(unused_z));

	tmp_qmul #(.W(W), .F(F)) u_ux (.clk, .en, .a(tx_s1), .b(inv_s1), .p(ux_s2), .ovf(unused_a));
	tmp_qmul #(.W(W), .F(F)) u_uy (.clk, .en, .a(ty_s1), .b(inv_s1), .p(uy_s2), .ovf(unused_b));
	tmp_qmul #(.W(W), .F(F)) u_uz (.clk, .en, .a(tz_s1), .b(inv_s1), .p(uz_s2), .ovf(unused_c));

	function automatic logic signed [W-1:0] qadd(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) begin
			return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end
		return s[W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s2  <= ovf_s1;
			inv_ovf <= ovf_s2;
			scr_x   <= qadd(ox, ux_s2);
			scr_y   <= qadd(oy, uy_s2);
			scr_z   <= qadd(oz, uz_s2);
		end
	end
endmodule
`default_nettype wire

@@ rtl/triangle_midpoint_project.sv @@
// ----------------------------------------------------------------------------
// triangle_midpoint_project
// Edge midpoints of a clip-space triangle, shared w reciprocal, and three
// parallel projection lanes merged onto one result channel.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  item    | in  | one triangle: a, b, c clip x y z w
//  res     | out | one edge midpoint with screen x y z, fault, last
//  cfg     | in  | one register write, index and data
//
//  The triangle rate is set by the three result beats per triangle on res;
//  the pipeline (divider one quotient bit per stage) takes a new triangle
//  in every cycle in which it advances.
//  A finished triangle waiting for the merge buffer holds the whole pipeline
//  until the last beat of the previous triangle. cfg is always ready.
//  Reset clears valid state and loads offsets 0, scales 1.0.
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_midpoint_project #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	tmp_item_if.sink    item,
	tmp_res_if.source   res,
	tmp_cfg_if.sink     cfg
);
	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int NE = tmp_pkg::N_EDGES;
	localparam int NC = tmp_pkg::N_COMP;
	localparam int WX = tmp_pkg::COMP_W;

	typedef logic [NE-1:0][NC-1:0][W-1:0] mids_t;

	typedef struct packed {
		mids_t                m;
		logic [NE-1:0][W-1:0] pair;
		logic                 fault;
	} div_pl_t;

	// configuration
	logic signed [W-1:0] off_x_q, scl_x_q, off_y_q, scl_y_q, off_z_q, scl_z_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			scl_x_q <= W'(1) << F;
			off_y_q <= '0;
			scl_y_q <= W'(1) << F;
			off_z_q <= '0;
			scl_z_q <= W'(1) << F;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tmp_pkg::CFG_OFFSET_X: off_x_q <= cfg.data;
				tmp_pkg::CFG_SCALE_X:  scl_x_q <= cfg.data;
				tmp_pkg::CFG_OFFSET_Y: off_y_q <= cfg.data;
				tmp_pkg::CFG_SCALE_Y:  scl_y_q <= cfg.data;
				tmp_pkg::CFG_OFFSET_Z: off_z_q <= cfg.data;
				tmp_pkg::CFG_SCALE_Z:  scl_z_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic en, load_ok, busy_q, beat;
	logic v_s1, v_s2, v_s3, v_d, v_p1, v_p2, v_p3;
	tmp_pkg::edge_t idx_q;

	assign beat    = busy_q & res.ready;
	assign load_ok = !busy_q | (beat & (idx_q == tmp_pkg::EDGE_AC));
	assign en      = !v_p3 | load_ok;
	assign item.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_p1 <= v_d;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
		end
	end

	// stage 1: midpoints, floor of half sum
	logic [tmp_pkg::N_VTX-1:0][NC-1:0][W-1:0] vtx;
	mids_t m_s1, m_s2, m_s3, m_p1, m_p2, m_p3;

	always_comb begin
		vtx[0] = {item.a_w, item.a_z, item.a_y, item.a_x};
		vtx[1] = {item.b_w, item.b_z, item.b_y, item.b_x};
		vtx[2] = {item.c_w, item.c_z, item.c_y, item.c_x};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NE; e++) begin
				for (int c = 0; c < NC; c++) begin
					m_s1[e][c] <= W'(({vtx[tmp_pkg::END_A[e]][c][W-1],
						vtx[tmp_pkg::END_A[e]][c]} +
						{vtx[tmp_pkg::END_B[e]][c][W-1],
						vtx[tmp_pkg::END_B[e]][c]}) >> 1);
				end
			end
		end
	end

	// stage 2: pair products of midpoint w
	logic [NE-1:0][W-1:0] pair_s2, pair_s3;
	logic [NE-1:0]        pair_ovf;

	tmp_qmul #(.W(W), .F(F)) u_pair0 (.clk, .en, .a(m_s1[1][WX]), .b(m_s1[2][WX]),
		.p(pair_s2[0]), .ovf(pair_ovf[0]));
	tmp_qmul #(.W(W), .F(F)) u_pair1 (.clk, .en, .a(m_s1[0][WX]), .b(m_s1[2][WX]),
		.p(pair_s2[1]), .ovf(pair_ovf[1]));
	tmp_qmul #(.W(W), .F(F)) u_pair2 (.clk, .en, .a(m_s1[0][WX]), .b(m_s1[1][WX]),
		.p(pair_s2[2]), .ovf(pair_ovf[2]));

	// stage 3: triple product
	logic signed [W-1:0] triple_s3;
	logic                triple_ovf, fault_s3;

	tmp_qmul #(.W(W), .F(F)) u_triple (.clk, .en, .a(m_s2[1][WX]), .b(pair_s2[1]),
		.p(triple_s3), .ovf(triple_ovf));

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2     <= m_s1;
			m_s3     <= m_s2;
			pair_s3  <= pair_s2;
			fault_s3 <= |pair_ovf;
		end
	end

	// shared reciprocal
	div_pl_t             pl_in, pl_out;
	logic signed [W-1:0] rcp;
	logic                rsat;

	always_comb begin
		pl_in.m     = m_s3;
		pl_in.pair  = pair_s3;
		pl_in.fault = fault_s3 | triple_ovf;
	end

	tmp_recip #(.W(W), .F(F), .PL_BITS($bits(div_pl_t))) u_recip (
		.clk, .arst_n, .en, .in_valid(v_s3), .p(triple_s3), .pl_in,
		.out_valid(v_d), .rcp, .sat(rsat), .pl_out
	);

	// projection lanes
	logic                fault_p1, fault_p2, fault_p3;
	logic [NE-1:0][W-1:0] scr_x, scr_y, scr_z;
	logic [NE-1:0]       inv_ovf;

	for (genvar e = 0; e < NE; e++) begin : g_lane
		tmp_lane #(.W(W), .F(F)) u_lane (
			.clk, .en, .pair(pl_out.pair[e]), .rcp,
			.mx(pl_out.m[e][tmp_pkg::COMP_X]), .my(pl_out.m[e][tmp_pkg::COMP_Y]),
			.mz(pl_out.m[e][tmp_pkg::COMP_Z]),
			.sx(scl_x_q), .sy(scl_y_q), .sz(scl_z_q),
			.ox(off_x_q), .oy(off_y_q), .oz(off_z_q),
			.scr_x(scr_x[e]), .scr_y(scr_y[e]), .scr_z(scr_z[e]),
			.inv_ovf(inv_ovf[e])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_p1     <= pl_out.m;
			m_p2     <= m_p1;
			m_p3     <= m_p2;
			fault_p1 <= pl_out.fault | rsat;
			fault_p2 <= fault_p1;
			fault_p3 <= fault_p2;
		end
	end

	// merge: hold one triangle, one edge per beat
	mids_t                m_q;
	logic [NE-1:0][W-1:0] sx_q, sy_q, sz_q;
	logic                 fault_q;
	logic                 load;

	assign load = v_p3 & en;

	always_ff @(posedge clk) begin
		if (load) begin
			m_q     <= m_p3;
			sx_q    <= scr_x;
			sy_q    <= scr_y;
			sz_q    <= scr_z;
			fault_q <= fault_p3 | (|inv_ovf);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= tmp_pkg::EDGE_AB;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= tmp_pkg::EDGE_AB;
		end else if (beat) begin
			unique case (idx_q)
				tmp_pkg::EDGE_AB: idx_q <= tmp_pkg::EDGE_BC;
				tmp_pkg::EDGE_BC: idx_q <= tmp_pkg::EDGE_AC;
				default: begin
					idx_q  <= tmp_pkg::EDGE_AB;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		res.valid    = busy_q;
		res.edge_res = idx_q;
		res.mid_x    = m_q[idx_q][tmp_pkg::COMP_X];
		res.mid_y    = m_q[idx_q][tmp_pkg::COMP_Y];
		res.mid_z    = m_q[idx_q][tmp_pkg::COMP_Z];
		res.mid_w    = m_q[idx_q][tmp_pkg::COMP_W];
		res.screen_x = sx_q[idx_q];
		res.screen_y = sy_q[idx_q];
		res.screen_z = sz_q[idx_q];
		res.w_fault  = fault_q;
		res.last     = (idx_q == tmp_pkg::EDGE_AC);
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q == tmp_pkg::EDGE_AB || idx_q == tmp_pkg::EDGE_BC ||
		idx_q == tmp_pkg::EDGE_AC))
		else $error("edge index out of range");
	a_fault_held: assert property (@(posedge clk) disable iff (!arst_n)
		(beat && idx_q != tmp_pkg::EDGE_AC) |=> (busy_q && res.w_fault == $past(res.w_fault)))
		else $error("fault changed inside a triangle");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_p3 && !en) |=> v_p3)
		else $error("finished triangle lost under stall");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (busy_q && idx_q == tmp_pkg::EDGE_AB))
		else $error("merge buffer not started on load");
`endif
endmodule
`default_nettype wire
